### rtl/core/fip_pkg.sv
// Shared types, character codes and sizes of the format integer printer.
`default_nettype none

package fip_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int QUEUE_DEPTH     = 2;

    // ASCII codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_ALPHA   = 8'h37; // 'A' less ten
    localparam logic [7:0] CH_LC_D    = 8'h64;
    localparam logic [7:0] CH_LC_S    = 8'h73;
    localparam logic [7:0] CH_LC_U    = 8'h75;
    localparam logic [7:0] CH_LC_X    = 8'h78;

    // numeric part of a command
    typedef enum logic [1:0] {
        NK_NONE,
        NK_HEX,
        NK_DEC
    } t_num_kind;

    // one queued command: up to two literal chars, then an optional number
    typedef struct packed {
        t_num_kind  kind;
        logic [1:0] nlit;
        logic [7:0] lit0;
        logic [7:0] lit1;
    } t_cmd_ctl;

    localparam int CMD_CTL_W = $bits(t_cmd_ctl);

endpackage

`default_nettype wire

### rtl/core/fip_front.sv
// Front end: takes input words, tracks the pending percent, builds commands.
`default_nettype none

module fip_front import fip_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [71:0]            s_axis_tdata,  // ch[7:0], value[71:8]
    input  logic                   s_axis_tuser,  // opcode
    input  logic                   s_axis_tlast,  // end_of_format
    input  logic                   i_full,
    output logic                   o_push,
    output t_cmd_ctl               o_ctl,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic                   r_pending;
    logic                   n_pending;
    logic                   accept;
    logic [7:0]             ch;
    logic [VALUE_WIDTH-1:0] value;

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ch            = s_axis_tdata[7:0];
    assign value         = s_axis_tdata[8 +: VALUE_WIDTH];

    always_comb begin
        n_pending  = r_pending;
        o_ctl.kind = NK_NONE;
        o_ctl.nlit = 2'd0;
        o_ctl.lit0 = ch;
        o_ctl.lit1 = CH_PERCENT;
        o_value    = value;
        if (s_axis_tuser) begin
            o_ctl.nlit = 2'd1;
        end else if (r_pending) begin
            n_pending = 1'b0;
            unique case (ch)
                CH_LC_X: begin
                    o_ctl.kind = NK_HEX;
                    o_ctl.nlit = 2'd2;
                    o_ctl.lit0 = CH_ZERO;
                    o_ctl.lit1 = CH_LC_X;
                end
                CH_LC_U: begin
                    o_ctl.kind = NK_DEC;
                end
                CH_LC_D: begin
                    o_ctl.kind = NK_DEC;
                    if (value[VALUE_WIDTH-1]) begin
                        o_ctl.nlit = 2'd1;
                        o_ctl.lit0 = CH_MINUS;
                        o_value    = ~value + 1'b1;
                    end
                end
                CH_LC_S: begin
                    o_ctl.nlit = 2'd0;
                end
                default: begin
                    // stray percent is printed, the byte is then taken afresh
                    o_ctl.lit0 = CH_PERCENT;
                    if (ch == CH_PERCENT) begin
                        if (s_axis_tlast) begin
                            o_ctl.nlit = 2'd2;
                        end else begin
                            o_ctl.nlit = 2'd1;
                            n_pending  = 1'b1;
                        end
                    end else begin
                        o_ctl.nlit = 2'd2;
                        o_ctl.lit1 = ch;
                    end
                end
            endcase
        end else if (ch == CH_PERCENT) begin
            // a percent left open at the end of the format is printed
            n_pending = !s_axis_tlast;
            if (s_axis_tlast) begin
                o_ctl.nlit = 2'd1;
            end
        end else begin
            o_ctl.nlit = 2'd1;
        end
    end

    assign o_push = accept && ((o_ctl.nlit != 2'd0) || (o_ctl.kind != NK_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fip_queue.sv
// Small command queue between front end and back end.
`default_nettype none

module fip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/fip_back.sv
// Back end: plays out literal chars and converts numbers, at most one char a cycle while m_axis_tready allows.
`default_nettype none

module fip_back import fip_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  t_cmd_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,  // out_char
    output logic                   m_axis_tlast   // last
);

    localparam int NIB   = (VALUE_WIDTH + 3) / 4;
    localparam int HW    = NIB * 4;
    localparam int DEC   = (VALUE_WIDTH * 78) / 256 + 1; // >= decimal digits
    localparam int BCD_W = DEC * 4;
    localparam int CNT_W = $clog2(DEC + 1);
    localparam int IT_W  = $clog2(NIB + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_CONV,
        ST_SKIP,
        ST_DIGIT
    } t_state;

    t_state           r_state,     n_state;
    t_cmd_ctl         r_ctl,       n_ctl;
    logic             r_lit_idx,   n_lit_idx;
    logic [HW-1:0]    r_num,       n_num;
    logic [BCD_W-1:0] r_bcd,       n_bcd;
    logic [CNT_W-1:0] r_cnt,       n_cnt;
    logic [IT_W-1:0]  r_iter,      n_iter;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char,  n_out_char;
    logic             r_out_last,  n_out_last;
    logic             out_free;
    logic             lit_done;
    logic [3:0]       top_digit;

    // four double-dabble steps, value bits fed most significant first
    function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd,
                                                 input logic [3:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int b = 3; b >= 0; b--) begin
            for (int i = 0; i < DEC; i++) begin
                if (acc[i*4 +: 4] >= 4'd5) begin
                    acc[i*4 +: 4] = acc[i*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[b]};
        end
        dabble4 = acc;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = (d < 4'd10) ? CH_ZERO + {4'h0, d} : CH_ALPHA + {4'h0, d};
    endfunction

    assign out_free  = !r_out_valid || m_axis_tready;
    assign lit_done  = r_lit_idx || (r_ctl.nlit == 2'd1);
    assign top_digit = r_bcd[BCD_W-1 -: 4];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_ctl       = r_ctl;
        n_lit_idx   = r_lit_idx;
        n_num       = r_num;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_ctl     = i_ctl;
                    n_lit_idx = 1'b0;
                    n_num     = '0;
                    n_num[VALUE_WIDTH-1:0] = i_value;
                    n_bcd     = '0;
                    if (i_ctl.kind == NK_HEX) begin
                        n_bcd[VALUE_WIDTH-1:0] = i_value;
                    end
                    n_cnt  = CNT_W'(DEC);
                    n_iter = IT_W'(NIB);
                    if (i_ctl.nlit != 2'd0) begin
                        n_state = ST_LIT;
                    end else if (i_ctl.kind == NK_DEC) begin
                        n_state = ST_CONV;
                    end else if (i_ctl.kind == NK_HEX) begin
                        n_state = ST_SKIP;
                    end
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_lit_idx ? r_ctl.lit1 : r_ctl.lit0;
                    n_out_last  = lit_done && (r_ctl.kind == NK_NONE);
                    n_lit_idx   = 1'b1;
                    if (lit_done) begin
                        unique case (r_ctl.kind)
                            NK_DEC:  n_state = ST_CONV;
                            NK_HEX:  n_state = ST_SKIP;
                            default: n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_CONV: begin
                n_bcd  = dabble4(r_bcd, r_num[HW-1 -: 4]);
                n_num  = r_num << 4;
                n_iter = r_iter - 1'b1;
                if (r_iter == IT_W'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if ((r_cnt > CNT_W'(1)) && (top_digit == 4'd0)) begin
                    n_bcd = r_bcd << 4;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_char(top_digit);
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_bcd       = r_bcd << 4;
                    n_cnt       = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_ctl      <= n_ctl;
        r_lit_idx  <= n_lit_idx;
        r_num      <= n_num;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_iter     <= n_iter;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

`default_nettype wire

### rtl/core/format_integer_printer.sv
// Top level of the printf-style format expander for %x, %u, %d and %s.
//
//  channel | direction | tdata              | tuser  | tlast
//  s_axis  | in        | ch[7:0] value[71:8]| opcode | end_of_format
//  m_axis  | out       | out_char[7:0]      | -      | last
//
// Sequence: a command is first popped into the back end, then its literal
//   characters go out in order. %u and %d then run the binary-to-BCD
//   conversion (four bits a cycle), drop each suppressed leading zero in
//   turn, and send one digit per output character. %x skips leading zeros
//   the same way.
// Reset: synchronous, active low; clears the pending percent, the queue, the
//   back-end state and the output valid. No clearing pass.
// Stalls: the front end takes words while the two-entry queue has room, so
//   it keeps going while the back end waits on m_axis_tready.
`default_nettype none

module format_integer_printer import fip_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // ch[7:0], value[71:8]
    input  logic        s_axis_tuser,  // opcode: 0 format byte, 1 string byte
    input  logic        s_axis_tlast,  // end_of_format
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_char
    output logic        m_axis_tlast   // last char of this word's output
);

    localparam int Q_W = VALUE_WIDTH + CMD_CTL_W;

    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    t_cmd_ctl               front_ctl;
    logic [VALUE_WIDTH-1:0] front_value;
    logic [Q_W-1:0]         q_out;
    t_cmd_ctl               back_ctl;
    logic [VALUE_WIDTH-1:0] back_value;

    fip_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (q_full),
        .o_push        (push),
        .o_ctl         (front_ctl),
        .o_value       (front_value)
    );

    // command queue: value above the control struct
    fip_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_value, front_ctl}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign back_ctl   = q_out[CMD_CTL_W-1:0];
    assign back_value = q_out[Q_W-1:CMD_CTL_W];

    fip_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_empty),
        .o_pop         (pop),
        .i_ctl         (back_ctl),
        .i_value       (back_value),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/fip_checker.sv
// Port-level checks on the output stream of the format integer printer.
`default_nettype none

module fip_checker import fip_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic       r_prev_last;
    logic [7:0] r_prev_char;
    logic       out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // last word taken on the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
        end else if (out_acc) begin
            r_prev_last <= m_axis_tlast;
        end
        if (out_acc) begin
            r_prev_char <= m_axis_tdata;
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // a non-final 'x' only appears inside the hex prefix
    a_hex_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && (m_axis_tdata == CH_LC_X) && !m_axis_tlast
        |-> !r_prev_last && (r_prev_char == CH_ZERO))
        else $error("hex digits without 0 before x");

    // a non-final minus sign is followed by a decimal digit
    a_sign_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !r_prev_last && (r_prev_char == CH_MINUS)
        |-> (m_axis_tdata >= CH_ZERO) && (m_axis_tdata <= CH_NINE))
        else $error("minus sign not followed by a digit");

endmodule

bind format_integer_printer fip_checker u_fip_checker (.*);

`default_nettype wire

### tb/tb_format_integer_printer.sv
// Self-checking testbench for the format integer printer stream block.
`timescale 1ns / 1ps

module tb_format_integer_printer import fip_pkg::*;;

    localparam bit OP_FMT      = 1'b0;   // format string byte
    localparam bit OP_STR      = 1'b1;   // string argument byte, passed through
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 360;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 120;    // beyond the slowest %u / %d word
    localparam int MAX_SHOWN   = 10;

    // Expands each accepted format word into the characters it should give and
    // compares the block's output against them in order.
    class printf_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } t_due_char;

        t_due_char   due_chars[$];
        logic [7:0]  word_chars[$];
        bit          percent_pending;
        int unsigned fails;

        function void flag_error();
            fails++;
        endfunction

        function void put_plain(logic [7:0] c);
            if (c == CH_PERCENT)
                percent_pending = 1'b1;
            else
                word_chars.push_back(c);
        endfunction

        function void put_udec(logic [63:0] v);
            logic [7:0] digits[$];
            do begin
                digits.push_front(CH_ZERO + 8'(v % 64'd10));
                v = v / 64'd10;
            end while (v != 0);
            foreach (digits[i]) word_chars.push_back(digits[i]);
        endfunction

        function void put_hex(logic [63:0] v);
            logic [7:0] digits[$];
            logic [3:0] nib;
            word_chars.push_back(CH_ZERO);
            word_chars.push_back(CH_LC_X);
            do begin
                nib = v[3:0];
                digits.push_front(nib < 4'd10 ? CH_ZERO + 8'(nib) : CH_ALPHA + 8'(nib));
                v = v >> 4;
            end while (v != 0);
            foreach (digits[i]) word_chars.push_back(digits[i]);
        endfunction

        // one accepted input word
        function void note_word(bit op, logic [7:0] c, logic [63:0] v, bit eof);
            word_chars.delete();
            if (op == OP_STR) begin
                word_chars.push_back(c);
            end else begin
                if (percent_pending) begin
                    percent_pending = 1'b0;
                    case (c)
                        CH_LC_X: put_hex(v);
                        CH_LC_U: put_udec(v);
                        CH_LC_D: begin
                            if (v[63]) begin
                                word_chars.push_back(CH_MINUS);
                                put_udec(-v);
                            end else begin
                                put_udec(v);
                            end
                        end
                        CH_LC_S: ; // string bytes follow as separate words
                        default: begin
                            word_chars.push_back(CH_PERCENT);
                            put_plain(c);
                        end
                    endcase
                end else begin
                    put_plain(c);
                end
                // dangling '%' at the end of the format is printed as is
                if (eof && percent_pending) begin
                    percent_pending = 1'b0;
                    word_chars.push_back(CH_PERCENT);
                end
            end
            foreach (word_chars[i])
                due_chars.push_back('{ch: word_chars[i], last: (i == word_chars.size() - 1)});
        endfunction

        // one accepted output word
        function void check_char(logic [7:0] c, logic l);
            t_due_char want;
            if (due_chars.size() == 0) begin
                flag_error();
                if (fails <= MAX_SHOWN)
                    $display("%0t: unexpected char %h last %b", $time, c, l);
            end else begin
                want = due_chars.pop_front();
                if (want.ch !== c || want.last !== l) begin
                    flag_error();
                    if (fails <= MAX_SHOWN)
                        $display("%0t: char exp %h got %h, last exp %b got %b",
                                 $time, want.ch, c, want.last, l);
                end
            end
        endfunction

        function int outstanding();
            return due_chars.size();
        endfunction

        function void close_out();
            if (due_chars.size() != 0) begin
                if (fails < MAX_SHOWN)
                    $display("%0d characters never arrived", due_chars.size());
                fails += due_chars.size();
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;   // ch[7:0], value[71:8]
    logic        s_axis_tuser  = 1'b0; // opcode
    logic        s_axis_tlast  = 1'b0; // end_of_format
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // out_char
    logic        m_axis_tlast;         // last char of the word's output

    printf_scoreboard sb = new();

    int  words_sent  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;
    bit  quiet       = 1'b0;  // no idling on either side while set
    bit  hold_req    = 1'b0;

    format_integer_printer #(
        .VALUE_WIDTH(DEF_VALUE_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: checks on handshake, stalls at random, and runs the long
    // hold-off counted here when asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tready && m_axis_tvalid === 1'b1)
                sb.check_char(m_axis_tdata, m_axis_tlast);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 34);
            end
        end
    end

    function automatic logic [63:0] rand_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    // bias towards the bytes that steer the format state
    function automatic logic [7:0] rand_ch();
        case ($urandom_range(7))
            0:       return CH_PERCENT;
            1:       return CH_LC_X;
            2:       return CH_LC_U;
            3:       return CH_LC_D;
            4:       return CH_LC_S;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] rand_conv();
        case ($urandom_range(2))
            0:       return CH_LC_X;
            1:       return CH_LC_U;
            default: return CH_LC_D;
        endcase
    endfunction

    task automatic send_word(bit op, logic [7:0] c, logic [63:0] v, bit eof);
        while (!quiet && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, c};
        s_axis_tuser  <= op;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(op, c, v, eof);
        words_sent++;
    endtask

    // A well-formed format string: plain bytes, conversions, %s with its
    // string bytes, and now and then a '%' followed by something else.
    task automatic send_format();
        int n;
        bit eof;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            eof = (i == n - 1);
            case ($urandom_range(9))
                0, 1, 2: send_word(OP_FMT, 8'($urandom_range(255)), rand_value(), eof);
                3, 4, 5, 6, 7: begin
                    send_word(OP_FMT, CH_PERCENT, rand_value(), 1'b0);
                    send_word(OP_FMT, rand_conv(), rand_value(), eof);
                end
                8: begin
                    send_word(OP_FMT, CH_PERCENT, rand_value(), 1'b0);
                    send_word(OP_FMT, CH_LC_S, rand_value(), eof);
                    repeat ($urandom_range(4))
                        send_word(OP_STR, 8'($urandom_range(255)), rand_value(),
                                  1'($urandom_range(1)));
                end
                default: begin
                    send_word(OP_FMT, CH_PERCENT, rand_value(), 1'b0);
                    send_word(OP_FMT, rand_ch(), rand_value(), eof);
                end
            endcase
        end
    endtask

    // always lets at least one edge pass, so the caller never drives twice
    // in the same step
    task automatic wait_drained();
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    initial begin
        int  directed_words;
        bit  held;
        bit  paused;

        held   = 1'b0;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_word(OP_FMT, 8'h41, '0, 1'b0);                       // plain 'A'
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_X, '0, 1'b0);                     // 0x0
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_X, '1, 1'b0);                     // sixteen Fs
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_U, '1, 1'b0);                     // twenty digits
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_U, '0, 1'b0);                     // zero
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_D, 64'h8000_0000_0000_0000, 1'b0); // most negative
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_D, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        // string byte arriving while a '%' is pending leaves it pending
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_STR, 8'h51, '1, 1'b1);
        send_word(OP_FMT, CH_LC_D, '1, 1'b0);                     // -1
        send_word(OP_FMT, 8'h00, '1, 1'b0);                       // zero byte
        // percent after percent re-arms
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, 8'h71, '0, 1'b0);
        send_word(OP_FMT, CH_PERCENT, '0, 1'b1);                  // dangling '%'
        send_word(OP_FMT, CH_PERCENT, '0, 1'b0);
        send_word(OP_FMT, CH_LC_S, '0, 1'b1);                     // %s gives nothing
        send_word(OP_STR, 8'hFF, '0, 1'b0);
        send_word(OP_STR, CH_PERCENT, '1, 1'b1);
        directed_words = words_sent;

        // random
        while (words_sent < directed_words + RANDOM_WORDS) begin
            if (!held && words_sent > directed_words + 80) begin
                held     = 1'b1;
                hold_req = 1'b1;   // keep offering words while the receiver sits
            end
            if (!paused && words_sent > directed_words + 180) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            quiet = (words_sent > directed_words + 240) && (words_sent < directed_words + 300);
            if ($urandom_range(99) < 15)
                send_word(1'($urandom_range(1)), rand_ch(), rand_value(),
                          1'($urandom_range(1)));
            else
                send_format();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/fip_pkg.sv
rtl/core/fip_front.sv
rtl/core/fip_queue.sv
rtl/core/fip_back.sv
rtl/core/format_integer_printer.sv
rtl/core/fip_checker.sv
tb/tb_format_integer_printer.sv
